// ===== rtl/csl_pkg.sv =====
// Shared types and constants for the cursor sequence list.
// Depends on nothing; every other file of the block imports it.
package csl_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int REQ_TYPE_W = 3;
    localparam int ENTRY_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_REWIND  = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_INSERT  = 3'd2,
        REQ_ATTACH  = 3'd3,
        REQ_REMOVE  = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_NO_CURRENT = 2'd1,
        ST_FULL       = 2'd2
    } status_t;

    // What one cell takes on the next edge
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_FROM_LEFT,
        OP_FROM_RIGHT,
        OP_LOAD
    } cell_op_t;

    // Where a cell sits relative to the cursor slot
    typedef enum logic [1:0] {
        REGION_BEFORE,
        REGION_CURRENT,
        REGION_AFTER
    } region_t;

    typedef struct packed {
        cell_op_t before_op;
        cell_op_t current_op;
        cell_op_t after_op;
    } cell_ctrl_t;

endpackage

// ===== rtl/csl_req_if.sv =====
// Request channel of the cursor sequence list: valid/ready and one request.
// Depends on csl_pkg.
interface csl_req_if;
    import csl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [ENTRY_W-1:0]    entry;

    modport source (output valid, req_type, entry, input ready);
    modport sink   (input valid, req_type, entry, output ready);
endinterface

// ===== rtl/csl_rsp_if.sv =====
// Result channel of the cursor sequence list: valid/ready and one result.
// Depends on csl_pkg.
interface csl_rsp_if;
    import csl_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  item_count;
    logic                has_current;
    logic [ENTRY_W-1:0]  current_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, item_count, has_current, current_value, status,
                    input ready);
    modport sink   (input valid, item_count, has_current, current_value, status,
                    output ready);
endinterface

// ===== rtl/csl_cell.sv =====
// One storage cell of the sequence chain: holds a value, takes a neighbour's.
// Depends on csl_pkg.
module csl_cell #(
    parameter int               VALUE_BITS = csl_pkg::VALUE_BITS_DEF,
    parameter csl_pkg::region_t REGION     = csl_pkg::REGION_AFTER
) (
    input  logic                    clk,
    input  csl_pkg::cell_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]   load_value,
    input  logic [VALUE_BITS-1:0]   from_left,
    input  logic [VALUE_BITS-1:0]   from_right,
    output logic [VALUE_BITS-1:0]   value
);
    import csl_pkg::*;

    cell_op_t              op;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    always_comb
    begin
        if (REGION == REGION_BEFORE)
        begin
            op = ctrl.before_op;
        end
        else if (REGION == REGION_CURRENT)
        begin
            op = ctrl.current_op;
        end
        else
        begin
            op = ctrl.after_op;
        end
    end

    always_comb
    begin
        unique case (op)
            OP_FROM_LEFT:  value_next = from_left;
            OP_FROM_RIGHT: value_next = from_right;
            OP_LOAD:       value_next = load_value;
            default:       value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/csl_chain.sv =====
// Row of 2*CAPACITY cells with the cursor slot at cell CAPACITY.
// Depends on csl_pkg and csl_cell.
module csl_chain #(
    parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  csl_pkg::cell_ctrl_t   ctrl,
    input  logic [VALUE_BITS-1:0] load_value,
    output logic [VALUE_BITS-1:0] cur_value,
    output logic [VALUE_BITS-1:0] next_value
);
    import csl_pkg::*;

    localparam int CELLS = 2 * CAPACITY;

    // tap[j+1] is cell j; the two end taps feed zero into the row
    logic [VALUE_BITS-1:0] tap [CELLS+2];

    assign tap[0]       = '0;
    assign tap[CELLS+1] = '0;

    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        localparam region_t CELL_REGION = (j < CAPACITY)  ? REGION_BEFORE :
                                          (j == CAPACITY) ? REGION_CURRENT :
                                                            REGION_AFTER;
        csl_cell #(
            .VALUE_BITS (VALUE_BITS),
            .REGION     (CELL_REGION)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_value (load_value),
            .from_left  (tap[j]),
            .from_right (tap[j+2]),
            .value      (tap[j+1])
        );
    end

    assign cur_value  = tap[CAPACITY+1];
    assign next_value = tap[CAPACITY+2];

endmodule

// ===== rtl/csl_ctrl.sv =====
// Request sequencer: cursor position, item count, chain control, result register.
// Depends on csl_pkg, csl_req_if and csl_rsp_if.
module csl_ctrl #(
    parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    csl_req_if.sink               req,
    csl_rsp_if.source             rsp,
    input  logic [VALUE_BITS-1:0] cur_value,
    input  logic [VALUE_BITS-1:0] next_value,
    output csl_pkg::cell_ctrl_t   chain_ctrl,
    output logic [VALUE_BITS-1:0] load_value
);
    import csl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [REQ_TYPE_W-1:0] req_type_reg;
    logic [VALUE_BITS-1:0] entry_reg;
    logic                  rewind_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      pos_next;

    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_has_reg;
    logic [ENTRY_W-1:0]    out_value_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  has_cur;
    logic                  full;
    logic                  out_free;
    logic                  accept;
    logic                  shifting;
    logic                  finish;
    logic                  rewind_in;
    status_t               status_next;
    logic [VALUE_BITS-1:0] slot_next;
    logic                  has_next;
    logic [63:0]           entry_wide;
    logic [63:0]           value_wide;

    assign has_cur  = pos_reg < count_reg;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;
    assign shifting = (state_reg == S_EXEC) && rewind_reg && (pos_reg != '0);
    assign finish   = (state_reg == S_EXEC) && !shifting && out_free;

    // Bring every item ahead of the cursor back to the front first
    assign rewind_in = (req.req_type == REQ_REWIND) ||
                       ((req.req_type == REQ_INSERT) && !has_cur && !full);

    assign entry_wide = 64'(req.entry);
    assign load_value = entry_reg;

    always_comb
    begin
        chain_ctrl  = '{before_op: OP_HOLD, current_op: OP_HOLD, after_op: OP_HOLD};
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = ST_DONE;
        slot_next   = cur_value;

        if (shifting)
        begin
            chain_ctrl = '{before_op: OP_FROM_LEFT, current_op: OP_FROM_LEFT,
                           after_op: OP_FROM_LEFT};
            pos_next   = pos_reg - CNT_W'(1);
        end
        else if (finish)
        begin
            unique case (req_type_reg)
                REQ_REWIND:
                begin
                    status_next = ST_DONE;
                end
                REQ_ADVANCE:
                begin
                    if (!has_cur)
                    begin
                        status_next = ST_NO_CURRENT;
                    end
                    else
                    begin
                        chain_ctrl = '{before_op: OP_FROM_RIGHT, current_op: OP_FROM_RIGHT,
                                       after_op: OP_FROM_RIGHT};
                        pos_next   = pos_reg + CNT_W'(1);
                        slot_next  = next_value;
                    end
                end
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        chain_ctrl = '{before_op: OP_HOLD, current_op: OP_LOAD,
                                       after_op: OP_FROM_LEFT};
                        count_next = count_reg + CNT_W'(1);
                        slot_next  = entry_reg;
                    end
                end
                REQ_ATTACH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // With a current item it moves behind the cursor
                        chain_ctrl.current_op = OP_LOAD;
                        if (has_cur)
                        begin
                            chain_ctrl.before_op = OP_FROM_RIGHT;
                            pos_next             = pos_reg + CNT_W'(1);
                        end
                        count_next = count_reg + CNT_W'(1);
                        slot_next  = entry_reg;
                    end
                end
                REQ_REMOVE:
                begin
                    if (!has_cur)
                    begin
                        status_next = ST_NO_CURRENT;
                    end
                    else
                    begin
                        chain_ctrl = '{before_op: OP_HOLD, current_op: OP_FROM_RIGHT,
                                       after_op: OP_FROM_RIGHT};
                        count_next = count_reg - CNT_W'(1);
                        slot_next  = next_value;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    assign has_next   = pos_next < count_next;
    assign value_wide = has_next ? 64'(slot_next) : 64'd0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rewind_reg    <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;

            if (accept)
            begin
                req_type_reg <= req.req_type;
                entry_reg    <= entry_wide[VALUE_BITS-1:0];
                rewind_reg   <= rewind_in;
            end

            if (finish)
            begin
                out_valid_reg  <= 1'b1;
                out_count_reg  <= COUNT_W'(count_next);
                out_has_reg    <= has_next;
                out_value_reg  <= value_wide[ENTRY_W-1:0];
                out_status_reg <= status_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.item_count    = out_count_reg;
    assign rsp.has_current   = out_has_reg;
    assign rsp.current_value = out_value_reg;
    assign rsp.status        = out_status_reg;

endmodule

// ===== rtl/cursor_sequence_list.sv =====
// Top level of the cursor sequence list: sequencer plus a row of value cells.
// Depends on csl_pkg, csl_req_if, csl_rsp_if, csl_ctrl and csl_chain.
//
//  channel | dir | payload                                        | accepted when
//  --------+-----+------------------------------------------------+---------------------
//  req     | in  | req_type[2:0], entry[31:0]                     | req.valid & req.ready
//  rsp     | out | item_count[6:0], has_current, current_value,   | rsp.valid & rsp.ready
//          |     | status[1:0]                                    |
//
// Sequence: an item is first accepted and then executed. A rewind, or an insert with
// no current item, first spends one shift step for each item ahead of the cursor,
// since the cell row shifts by one place a cycle.
// Reset: rst_n clears the sequencer; the sequence is empty and the cells need no clear.
// Stalls: a finished result waits in the output register while the next item is
// accepted; execution holds only when that register is still full.
//
// The ordered sequence lives in a row of 2*CAPACITY cells. The current item always sits
// in the cursor slot (cell CAPACITY); items before the cursor fill the cells to its left
// in order, items after it the cells to its right. Advancing shifts the whole row left,
// inserting opens a gap by shifting the right half, removing closes it. The sequencer
// keeps the item count and the cursor position (items ahead of the cursor); the cursor
// names an item exactly when position < count.
module cursor_sequence_list #(
    parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = csl_pkg::VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    csl_req_if.sink   req,
    csl_rsp_if.source rsp
);
    import csl_pkg::*;

    cell_ctrl_t            chain_ctrl;
    logic [VALUE_BITS-1:0] load_value;
    logic [VALUE_BITS-1:0] cur_value;
    logic [VALUE_BITS-1:0] next_value;

    // Decode each item, track count and cursor, hold the result
    csl_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cur_value  (cur_value),
        .next_value (next_value),
        .chain_ctrl (chain_ctrl),
        .load_value (load_value)
    );

    // Hold the values; shift them around the cursor slot on command
    csl_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .clk        (clk),
        .ctrl       (chain_ctrl),
        .load_value (load_value),
        .cur_value  (cur_value),
        .next_value (next_value)
    );

endmodule

// ===== rtl/csl_checker.sv =====
// Port checker for the cursor sequence list, bound to the top level.
// Depends on csl_pkg and cursor_sequence_list.
module csl_checker #(
    parameter int CAPACITY = csl_pkg::CAPACITY_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [csl_pkg::COUNT_W-1:0]    item_count,
    input logic                           has_current,
    input logic [csl_pkg::ENTRY_W-1:0]    current_value,
    input logic [csl_pkg::STATUS_W-1:0]   status
);
    import csl_pkg::*;

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_count) &&
            $stable(has_current) && $stable(current_value) && $stable(status))
        else $error("result changed while stalled");

    // No current item reads as zero
    a_no_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_current |-> current_value == '0)
        else $error("value shown without a current item");

    // A full refusal only with the store full; the count never exceeds it
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (item_count <= COUNT_W'(CAPACITY)) &&
            (status != ST_FULL || item_count == COUNT_W'(CAPACITY)))
        else $error("count out of range or false full refusal");

    // Accepting an item makes the block busy while it executes
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is executing");

endmodule

bind cursor_sequence_list csl_checker #(
    .CAPACITY (CAPACITY)
) u_csl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .item_count    (rsp.item_count),
    .has_current   (rsp.has_current),
    .current_value (rsp.current_value),
    .status        (rsp.status)
);
